// ===== src/p2km_pkg.sv =====
package p2km_pkg;

    localparam logic       KIND_SCAN = 1'b0;
    localparam logic       KIND_READ = 1'b1;

    localparam logic [7:0] SCAN_NONE = 8'h00;
    localparam logic [7:0] SCAN_EXT  = 8'hE0;
    localparam logic [7:0] SCAN_REL  = 8'hF0;

    localparam int         MATRIX_DIM = 8;
    localparam int         KEY_SLOTS  = 256;

    // matrix position row*8+col -> scan-code slot; 0 marks an empty position
    localparam logic [7:0] KEY_MAP [64] = '{
        8'h16, 8'h1E, 8'h26, 8'h25, 8'h2E, 8'h36, 8'h3D, 8'h00,
        8'h3E, 8'h46, 8'h45, 8'h52, 8'h4E, 8'h66, 8'h00, 8'h00,
        8'h49, 8'h4B, 8'h44, 8'h00, 8'h5A, 8'h00, 8'h00, 8'h00,
        8'h1D, 8'h24, 8'h2D, 8'h2C, 8'h35, 8'h3C, 8'h43, 8'h00,
        8'h1B, 8'h23, 8'h2B, 8'h34, 8'h33, 8'h3B, 8'h42, 8'h00,
        8'h22, 8'h21, 8'h2A, 8'h32, 8'h31, 8'h3A, 8'h41, 8'h00,
        8'h15, 8'h1C, 8'h1A, 8'h29, 8'h4A, 8'h4C, 8'h4D, 8'h00,
        8'h00, 8'h14, 8'h76, 8'h00, 8'h00, 8'h12, 8'h59, 8'h00
    };

endpackage

// ===== src/ps2_to_key_matrix.sv =====
// PS/2 scan stream to 8x8 key matrix.
// An accepted read beat passes through the input reg, then the result reg, to give its column beat.
// Throughput: one beat per cycle, but a read beat waits while a column beat is held; scan beats give no output beat.
// Key-down store is 256 flip-flops updated in the cycle a scan beat leaves the input reg.
// Reset (rst_n low, asynchronous) clears all keys, both prefix flags and all valids.
module ps2_to_key_matrix
    import p2km_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [15:0] s_tdata,   // [7:0] scan_byte, [15:8] row_select
    input  logic        s_tuser,   // [0] kind
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [7:0]  m_tdata    // [7:0] column_bits
);

    logic                 in_valid_reg;
    logic                 in_kind_reg;
    logic [7:0]           in_byte_reg;
    logic [7:0]           in_rows_reg;

    logic [KEY_SLOTS-1:0] key_down_reg;
    logic [KEY_SLOTS-1:0] key_down_next;
    logic                 ext_reg;
    logic                 ext_next;
    logic                 rel_reg;
    logic                 rel_next;

    logic                 out_valid_reg;
    logic                 out_valid_next;
    logic [7:0]           out_cols_reg;
    logic [7:0]           cols_next;

    logic                 out_free;
    logic                 in_fire;
    logic [7:0]           key_idx;
    logic [7:0]           rows_hi;
    logic [7:0]           cols_hi;

    assign out_free = !out_valid_reg || m_tready;
    assign in_fire  = in_valid_reg && ((in_kind_reg == KIND_SCAN) || out_free);
    assign s_tready = !in_valid_reg || in_fire;

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_cols_reg;

    assign key_idx = {ext_reg, in_byte_reg[6:0]};

    always_comb
    begin
        key_down_next = key_down_reg;
        ext_next      = ext_reg;
        rel_next      = rel_reg;
        if (in_fire && (in_kind_reg == KIND_SCAN))
        begin
            priority if (in_byte_reg == SCAN_NONE)
            begin
                ext_next = ext_reg;
            end
            else if (in_byte_reg == SCAN_EXT)
            begin
                ext_next = 1'b1;
            end
            else if (in_byte_reg == SCAN_REL)
            begin
                rel_next = 1'b1;
            end
            else
            begin
                key_down_next[key_idx] = !rel_reg;
                ext_next               = 1'b0;
                rel_next               = 1'b0;
            end
        end
    end

    // OR the pressed columns over every driven row
    always_comb
    begin
        rows_hi = ~in_rows_reg;
        cols_hi = '0;
        for (int r = 0; r < MATRIX_DIM; r++)
        begin
            for (int c = 0; c < MATRIX_DIM; c++)
            begin
                if (rows_hi[MATRIX_DIM-1-r] && key_down_reg[KEY_MAP[r*MATRIX_DIM+c]])
                begin
                    cols_hi[MATRIX_DIM-1-c] = 1'b1;
                end
            end
        end
        cols_next = ~cols_hi;
    end

    always_comb
    begin
        out_valid_next = out_valid_reg && !m_tready;
        if (in_fire && (in_kind_reg == KIND_READ))
        begin
            out_valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            key_down_reg  <= '0;
            ext_reg       <= 1'b0;
            rel_reg       <= 1'b0;
        end
        else
        begin
            if (s_tready)
            begin
                in_valid_reg <= s_tvalid;
            end
            out_valid_reg <= out_valid_next;
            key_down_reg  <= key_down_next;
            ext_reg       <= ext_next;
            rel_reg       <= rel_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_tready && s_tvalid)
        begin
            in_kind_reg <= s_tuser;
            in_byte_reg <= s_tdata[7:0];
            in_rows_reg <= s_tdata[15:8];
        end
        if (in_fire && (in_kind_reg == KIND_READ))
        begin
            out_cols_reg <= cols_next;
        end
    end

endmodule

// ===== tb/testbench.sv =====
class key_matrix_model;
    bit [255:0] held;
    bit         ext_flag;
    bit         rel_flag;
    bit [7:0]   slot_of [64];
    bit [7:0]   column_q [$];
    int         errors;

    function new();
        slot_of = '{
            8'h16, 8'h1E, 8'h26, 8'h25, 8'h2E, 8'h36, 8'h3D, 8'h00,
            8'h3E, 8'h46, 8'h45, 8'h52, 8'h4E, 8'h66, 8'h00, 8'h00,
            8'h49, 8'h4B, 8'h44, 8'h00, 8'h5A, 8'h00, 8'h00, 8'h00,
            8'h1D, 8'h24, 8'h2D, 8'h2C, 8'h35, 8'h3C, 8'h43, 8'h00,
            8'h1B, 8'h23, 8'h2B, 8'h34, 8'h33, 8'h3B, 8'h42, 8'h00,
            8'h22, 8'h21, 8'h2A, 8'h32, 8'h31, 8'h3A, 8'h41, 8'h00,
            8'h15, 8'h1C, 8'h1A, 8'h29, 8'h4A, 8'h4C, 8'h4D, 8'h00,
            8'h00, 8'h14, 8'h76, 8'h00, 8'h00, 8'h12, 8'h59, 8'h00
        };
        held     = '0;
        ext_flag = 1'b0;
        rel_flag = 1'b0;
        errors   = 0;
    endfunction

    function void take_beat(bit kind, bit [7:0] scan, bit [7:0] rows);
        bit [7:0] sel;
        bit [7:0] cols;
        int       r;
        int       c;
        if (kind == p2km_pkg::KIND_READ)
        begin
            sel  = ~rows;
            cols = '0;
            for (r = 0; r < 8; r++)
                for (c = 0; c < 8; c++)
                    if (sel[7 - r] && held[slot_of[r * 8 + c]])
                        cols[7 - c] = 1'b1;
            column_q.push_back(~cols);
        end
        else if (scan == p2km_pkg::SCAN_EXT)
            ext_flag = 1'b1;
        else if (scan == p2km_pkg::SCAN_REL)
            rel_flag = 1'b1;
        else if (scan != p2km_pkg::SCAN_NONE)
        begin
            held[{ext_flag, scan[6:0]}] = !rel_flag;
            ext_flag = 1'b0;
            rel_flag = 1'b0;
        end
    endfunction

    function void log_fault(string what, bit [7:0] want, logic [7:0] got);
        errors++;
        if (errors <= 10)
            $display("%0t: %s: expected %02h, got %02h", $time, what, want, got);
    endfunction

    function void check_columns(logic [7:0] got);
        bit [7:0] want;
        if (column_q.size() == 0)
        begin
            log_fault("column beat with none pending", 8'h00, got);
            return;
        end
        want = column_q.pop_front();
        if (got !== want)
            log_fault("column_bits mismatch", want, got);
    endfunction
endclass

module testbench;
    import p2km_pkg::*;

    logic        clk;
    logic        rst_n;
    logic        s_tvalid;
    logic        s_tready;
    logic [15:0] s_tdata;   // [7:0] scan_byte, [15:8] row_select
    logic        s_tuser;   // [0] kind
    logic        m_tvalid;
    logic        m_tready;
    logic [7:0]  m_tdata;   // [7:0] column_bits

    key_matrix_model keys = new();
    bit              steady;
    int              hold_cycles;
    int              beats_sent;

    ps2_to_key_matrix u_top (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    initial
    begin
        clk = 1'b0;
    end

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    function automatic int draw_gap();
        return steady ? 0 : $urandom_range(0, 10);
    endfunction

    // other field carries random junk so every bit toggles
    task automatic send_beat(bit kind, bit [7:0] field);
        bit [7:0] scan;
        bit [7:0] rows;
        int       gap;
        scan = (kind == KIND_SCAN) ? field : 8'($urandom);
        rows = (kind == KIND_READ) ? field : 8'($urandom);
        gap  = draw_gap();
        repeat (gap)
        begin
            @(negedge clk);
            s_tvalid <= 1'b0;
        end
        @(negedge clk);
        s_tvalid <= 1'b1;
        s_tuser  <= kind;
        s_tdata  <= {rows, scan};
        do
            @(posedge clk);
        while (!s_tready);
        keys.take_beat(kind, scan, rows);
        beats_sent++;
    endtask

    function automatic bit [7:0] row_pattern();
        int pick;
        pick = $urandom_range(0, 9);
        if (pick < 5)
            return ~(8'h80 >> $urandom_range(0, 7));
        else if (pick == 5)
            return 8'hFF;
        else if (pick == 6)
            return 8'h00;
        return 8'($urandom);
    endfunction

    task automatic key_stroke();
        bit [7:0] code;
        if ($urandom_range(0, 9) < 8)
            code = keys.slot_of[$urandom_range(0, 63)];
        else
            code = 8'($urandom_range(1, 255));
        if ($urandom_range(0, 3) == 0)
            code[7] = 1'b1;
        if ($urandom_range(0, 7) == 0)
            send_beat(KIND_SCAN, SCAN_EXT);
        if ($urandom_range(0, 1) == 1)
            send_beat(KIND_SCAN, SCAN_REL);
        send_beat(KIND_SCAN, code);
    endtask

    task automatic noise();
        int pick;
        pick = $urandom_range(0, 3);
        if (pick == 0)
            send_beat(KIND_SCAN, SCAN_EXT);
        else if (pick == 1)
            send_beat(KIND_SCAN, SCAN_REL);
        else if (pick == 2)
            send_beat(KIND_SCAN, SCAN_NONE);
        else
            send_beat(KIND_SCAN, 8'($urandom));
    endtask

    // column sink
    initial
    begin
        int gap;
        m_tready = 1'b0;
        wait (rst_n === 1'b1);
        forever
        begin
            if (hold_cycles > 0)
            begin
                gap = hold_cycles;
                hold_cycles = 0;
            end
            else
                gap = draw_gap();
            repeat (gap)
            begin
                @(negedge clk);
                m_tready <= 1'b0;
            end
            @(negedge clk);
            m_tready <= 1'b1;
            do
                @(posedge clk);
            while (!m_tvalid);
            keys.check_columns(m_tdata);
        end
    end

    initial
    begin
        int i;
        int pick;
        rst_n       = 1'b0;
        s_tvalid    = 1'b0;
        s_tdata     = '0;
        s_tuser     = KIND_SCAN;
        steady      = 1'b0;
        hold_cycles = 0;
        beats_sent  = 0;
        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // directed
        send_beat(KIND_READ, 8'hFF);
        send_beat(KIND_READ, 8'h00);
        send_beat(KIND_SCAN, SCAN_NONE);
        send_beat(KIND_SCAN, 8'h16);
        send_beat(KIND_READ, 8'h7F);
        send_beat(KIND_READ, 8'hFF);
        send_beat(KIND_SCAN, SCAN_EXT);
        send_beat(KIND_SCAN, 8'h59);
        send_beat(KIND_SCAN, SCAN_REL);
        send_beat(KIND_SCAN, 8'h16);
        send_beat(KIND_READ, 8'h00);
        send_beat(KIND_SCAN, 8'h80);
        send_beat(KIND_READ, 8'h00);
        send_beat(KIND_READ, 8'hFE);
        send_beat(KIND_SCAN, SCAN_EXT);
        send_beat(KIND_SCAN, SCAN_EXT);
        send_beat(KIND_SCAN, SCAN_REL);
        send_beat(KIND_SCAN, SCAN_REL);
        send_beat(KIND_SCAN, 8'h80);
        send_beat(KIND_SCAN, 8'hFF);
        send_beat(KIND_SCAN, 8'hD9);
        send_beat(KIND_READ, 8'h00);
        send_beat(KIND_READ, 8'h01);

        i = 0;
        while (beats_sent < 1900)
        begin
            if (i % 100 == 0)
                steady = ($urandom_range(0, 3) == 0);
            if (i == 450)
            begin
                // sink stalls while reads keep coming
                steady      = 1'b1;
                hold_cycles = 300;
                repeat (60) send_beat(KIND_READ, row_pattern());
                steady = 1'b0;
            end
            pick = $urandom_range(0, 99);
            if (pick < 45)
                key_stroke();
            else if (pick < 90)
                send_beat(KIND_READ, row_pattern());
            else
                noise();
            i++;
        end
        @(negedge clk);
        s_tvalid <= 1'b0;

        while (keys.column_q.size() != 0)
            @(posedge clk);
        repeat (10) @(posedge clk);
        if (keys.errors == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

    initial
    begin
        #4000000;
        $display("Simulation FAILED");
        $finish;
    end
endmodule
